// ===== hw/rtl/mfhp_pkg.sv =====
// Package for the mesh frame header parser.
// Holds the register map, byte positions, frame kind codes and shared types.
// No dependencies.
package mfhp_pkg;

  localparam int MaxFrameLenDefault = 1023;

  localparam logic [2:0] REG_MAGIC_FIRST   = 3'd0;
  localparam logic [2:0] REG_MAGIC_SECOND  = 3'd1;
  localparam logic [2:0] REG_PROTO_VERSION = 3'd2;
  localparam logic [2:0] REG_CODE_REPORT   = 3'd3;
  localparam logic [2:0] REG_CODE_PATH_REQ = 3'd4;
  localparam logic [2:0] REG_CODE_PATH_RSP = 3'd5;
  localparam logic [2:0] REG_CODE_ACK      = 3'd6;
  localparam logic [2:0] REG_CODE_DATA     = 3'd7;

  localparam int BytePosMagic0  = 0;
  localparam int BytePosMagic1  = 1;
  localparam int BytePosVersion = 2;
  localparam int BytePosType    = 3;
  localparam int BytePosSource  = 4;
  localparam int BytePosByte5   = 5;
  localparam int BytePosSeqLow  = 6;
  localparam int BytePosSeqHigh = 7;
  localparam int BytePosPathLen = 8;
  localparam int BytePosHop     = 9;

  localparam int MinLenAny     = 5;
  localparam int MinLenReport  = 6;
  localparam int MinLenShort   = 8;
  localparam int PathStartRsp  = 9;
  localparam int PathStartData = 10;
  localparam int PayloadMax    = 1023;

  localparam logic [2:0] KIND_REPORT   = 3'd0;
  localparam logic [2:0] KIND_PATH_REQ = 3'd1;
  localparam logic [2:0] KIND_PATH_RSP = 3'd2;
  localparam logic [2:0] KIND_ACK      = 3'd3;
  localparam logic [2:0] KIND_DATA     = 3'd4;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] proto_version;
    logic [7:0] code_report;
    logic [7:0] code_path_req;
    logic [7:0] code_path_rsp;
    logic [7:0] code_ack;
    logic [7:0] code_data;
  } cfg_t;

  typedef struct packed {
    logic        bad;
    logic [7:0]  type_byte;
    logic [7:0]  source;
    logic [7:0]  byte5;
    logic [15:0] seq;
    logic [7:0]  path_size;
    logic [7:0]  hop;
  } hdr_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  kind;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] seq;
    logic [7:0]  path_size;
    logic [7:0]  hop;
    logic [7:0]  count;
    logic [3:0]  path_start;
    logic [8:0]  payload_start;
    logic [9:0]  payload_size;
  } res_t;

endpackage

// ===== hw/rtl/mfhp_capture.sv =====
// Byte position counter and header capture registers of the mesh frame parser.
// Hands a finished header record to the classifier at frame end.
// Depends on mfhp_pkg.
module mfhp_capture import mfhp_pkg::*; #(
  parameter int MAX_FRAME_LEN = MaxFrameLenDefault,
  parameter int POS_W = $clog2(MAX_FRAME_LEN + 2)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_end_i,
  input  cfg_t             cfg_i,
  output logic             rec_valid_o,
  output hdr_t             rec_hdr_o,
  output logic [POS_W-1:0] rec_len_o
);

  localparam logic [POS_W-1:0] PosCap = POS_W'(MAX_FRAME_LEN + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  hdr_t             hdr_q, hdr_d, hdr_upd;
  logic             rec_valid_q, rec_valid_d;
  hdr_t             rec_hdr_q, rec_hdr_d;
  logic [POS_W-1:0] rec_len_q, rec_len_d;

  always_comb begin
    hdr_upd = hdr_q;
    unique case (pos_q)
      POS_W'(BytePosMagic0):  if (rx_byte_i != cfg_i.magic_first) hdr_upd.bad = 1'b1;
      POS_W'(BytePosMagic1):  if (rx_byte_i != cfg_i.magic_second) hdr_upd.bad = 1'b1;
      POS_W'(BytePosVersion): if (rx_byte_i != cfg_i.proto_version) hdr_upd.bad = 1'b1;
      POS_W'(BytePosType):    hdr_upd.type_byte = rx_byte_i;
      POS_W'(BytePosSource):  hdr_upd.source = rx_byte_i;
      POS_W'(BytePosByte5):   hdr_upd.byte5 = rx_byte_i;
      POS_W'(BytePosSeqLow):  hdr_upd.seq[7:0] = rx_byte_i;
      POS_W'(BytePosSeqHigh): hdr_upd.seq[15:8] = rx_byte_i;
      POS_W'(BytePosPathLen): hdr_upd.path_size = rx_byte_i;
      POS_W'(BytePosHop):     hdr_upd.hop = rx_byte_i;
      default: ;
    endcase
    pos_inc = (pos_q < PosCap) ? pos_q + POS_W'(1) : pos_q;

    pos_d       = pos_q;
    hdr_d       = hdr_q;
    rec_valid_d = 1'b0;
    rec_hdr_d   = rec_hdr_q;
    rec_len_d   = rec_len_q;
    if (accept_i) begin
      if (frame_end_i) begin
        rec_valid_d = 1'b1;
        rec_hdr_d   = hdr_upd;
        rec_len_d   = pos_inc;
        pos_d       = '0;
        hdr_d       = '0;
      end else begin
        pos_d = pos_inc;
        hdr_d = hdr_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_q       <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_hdr_q <= rec_hdr_d;
    rec_len_q <= rec_len_d;
  end

  assign rec_valid_o = rec_valid_q;
  assign rec_hdr_o   = rec_hdr_q;
  assign rec_len_o   = rec_len_q;

endmodule

// ===== hw/rtl/mfhp_classify.sv =====
// Frame classifier of the mesh frame parser: decodes the type, checks the
// length limits and forms the result fields. Depends on mfhp_pkg.
module mfhp_classify import mfhp_pkg::*; #(
  parameter int MAX_FRAME_LEN = MaxFrameLenDefault,
  parameter int POS_W = $clog2(MAX_FRAME_LEN + 2)
) (
  input  cfg_t             cfg_i,
  input  hdr_t             hdr_i,
  input  logic [POS_W-1:0] len_i,
  output res_t             res_o
);

  localparam int CW = ((POS_W > 9) ? POS_W : 9) + 1;

  logic [CW-1:0] len_w, pl_w, min_rsp, min_data, data_diff, rep_diff;
  logic          base_ok, is_rep, is_req, is_ack, is_rsp, is_data;

  always_comb begin
    len_w     = CW'(len_i);
    pl_w      = CW'(hdr_i.path_size);
    min_rsp   = pl_w + CW'(PathStartRsp);
    min_data  = pl_w + CW'(PathStartData);
    data_diff = len_w - min_data;
    rep_diff  = len_w - CW'(MinLenReport);
    base_ok   = (len_w >= CW'(MinLenAny)) && (len_w <= CW'(MAX_FRAME_LEN)) && !hdr_i.bad;
    is_rep    = hdr_i.type_byte == cfg_i.code_report;
    is_req    = hdr_i.type_byte == cfg_i.code_path_req;
    is_ack    = hdr_i.type_byte == cfg_i.code_ack;
    is_rsp    = hdr_i.type_byte == cfg_i.code_path_rsp;
    is_data   = hdr_i.type_byte == cfg_i.code_data;

    res_o = '0;
    if (base_ok) begin
      if (is_rep) begin
        if (len_w >= CW'(MinLenReport)) begin
          res_o.ok            = 1'b1;
          res_o.kind          = KIND_REPORT;
          res_o.count         = hdr_i.byte5;
          res_o.payload_start = 9'(MinLenReport);
          res_o.payload_size  = (rep_diff > CW'(PayloadMax)) ? 10'(PayloadMax)
                                                             : rep_diff[9:0];
        end
      end else if (is_req || is_ack) begin
        if (len_w >= CW'(MinLenShort)) begin
          res_o.ok   = 1'b1;
          res_o.kind = is_req ? KIND_PATH_REQ : KIND_ACK;
          res_o.dst  = hdr_i.byte5;
          res_o.seq  = hdr_i.seq;
        end
      end else if (is_rsp) begin
        if (len_w >= min_rsp) begin
          res_o.ok         = 1'b1;
          res_o.kind       = KIND_PATH_RSP;
          res_o.dst        = hdr_i.byte5;
          res_o.seq        = hdr_i.seq;
          res_o.path_size  = hdr_i.path_size;
          res_o.path_start = 4'(PathStartRsp);
        end
      end else if (is_data) begin
        if (len_w >= min_data) begin
          res_o.ok         = 1'b1;
          res_o.kind       = KIND_DATA;
          res_o.dst        = hdr_i.byte5;
          res_o.seq        = hdr_i.seq;
          res_o.path_size  = hdr_i.path_size;
          res_o.hop        = hdr_i.hop;
          res_o.path_start = 4'(PathStartData);
          if (len_w > min_data) begin
            res_o.payload_start = min_data[8:0];
            res_o.payload_size  = (data_diff > CW'(PayloadMax)) ? 10'(PayloadMax)
                                                                : data_diff[9:0];
          end
        end
      end
    end
    if (res_o.ok) begin
      res_o.src = hdr_i.source;
    end
  end

endmodule

// ===== hw/rtl/mfhp_out_fifo.sv =====
// Two-entry result queue of the mesh frame parser, feeding the output channel.
// Depends on mfhp_pkg.
module mfhp_out_fifo import mfhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_t       push_data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       data_o,
  output logic [1:0] count_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/mesh_frame_header_parser.sv =====
// Mesh frame header parser: byte stream in, one header result per frame out.
// Top level; depends on mfhp_pkg, mfhp_capture, mfhp_classify, mfhp_out_fifo.
//
// Usage:
// Frame bytes enter on the input channel (in_valid_i, in_stall_o, rx_byte_i,
// frame_end_i), one byte per item, with frame_end_i high on the last byte.
// Each frame gives exactly one result item on the output channel
// (out_valid_o, out_stall_i and the result fields); bytes that do not end a
// frame give none. With an empty queue a result passes through the header
// record register and then the two-entry result queue before it can be taken.
// With a ready receiver a byte is taken every cycle. in_stall_o rises only
// when the queue and the header record register would hold two or more results
// after this cycle's output transfer, so the input backs up only while the
// receiver stalls. The configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no frame is in
// progress and no result is pending, as the block itself does not enforce it.
// Reset clears the byte position, the captured header, the result queue and
// loads the default magic, version and type codes.
module mesh_frame_header_parser import mfhp_pkg::*; #(
  parameter int MAX_FRAME_LEN = MaxFrameLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_ok_o,
  output logic [2:0] frame_kind_o,
  output logic [7:0] src_node_o,
  output logic [7:0] dst_node_o,
  output logic [15:0] seq_num_o,
  output logic [7:0] path_size_o,
  output logic [7:0] hop_index_o,
  output logic [7:0] report_count_o,
  output logic [3:0] path_start_o,
  output logic [8:0] payload_start_o,
  output logic [9:0] payload_size_o
);

  localparam int PosW = $clog2(MAX_FRAME_LEN + 2);

  cfg_t            cfg_q, cfg_d;
  logic            accept, pop;
  logic            rec_valid;
  hdr_t            rec_hdr;
  logic [PosW-1:0] rec_len;
  res_t            cls_res, out_res;
  logic [1:0]      q_count;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC_FIRST:   cfg_d.magic_first   = cfg_data_i;
        REG_MAGIC_SECOND:  cfg_d.magic_second  = cfg_data_i;
        REG_PROTO_VERSION: cfg_d.proto_version = cfg_data_i;
        REG_CODE_REPORT:   cfg_d.code_report   = cfg_data_i;
        REG_CODE_PATH_REQ: cfg_d.code_path_req = cfg_data_i;
        REG_CODE_PATH_RSP: cfg_d.code_path_rsp = cfg_data_i;
        REG_CODE_ACK:      cfg_d.code_ack      = cfg_data_i;
        REG_CODE_DATA:     cfg_d.code_data     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first   <= 8'd0;
      cfg_q.magic_second  <= 8'd0;
      cfg_q.proto_version <= 8'd0;
      cfg_q.code_report   <= 8'(KIND_REPORT);
      cfg_q.code_path_req <= 8'(KIND_PATH_REQ);
      cfg_q.code_path_rsp <= 8'(KIND_PATH_RSP);
      cfg_q.code_ack      <= 8'(KIND_ACK);
      cfg_q.code_data     <= 8'(KIND_DATA);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = (q_count == 2'd2) ? !(pop && !rec_valid)
                                        : ((q_count == 2'd1) && rec_valid && !pop);
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  mfhp_capture #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN),
    .POS_W        (PosW)
  ) u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .frame_end_i(frame_end_i),
    .cfg_i      (cfg_q),
    .rec_valid_o(rec_valid),
    .rec_hdr_o  (rec_hdr),
    .rec_len_o  (rec_len)
  );

  mfhp_classify #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN),
    .POS_W        (PosW)
  ) u_classify (
    .cfg_i(cfg_q),
    .hdr_i(rec_hdr),
    .len_i(rec_len),
    .res_o(cls_res)
  );

  mfhp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rec_valid),
    .push_data_i(cls_res),
    .pop_i      (pop),
    .valid_o    (out_valid_o),
    .data_o     (out_res),
    .count_o    (q_count)
  );

  assign frame_ok_o      = out_res.ok;
  assign frame_kind_o    = out_res.kind;
  assign src_node_o      = out_res.src;
  assign dst_node_o      = out_res.dst;
  assign seq_num_o       = out_res.seq;
  assign path_size_o     = out_res.path_size;
  assign hop_index_o     = out_res.hop;
  assign report_count_o  = out_res.count;
  assign path_start_o    = out_res.path_start;
  assign payload_start_o = out_res.payload_start;
  assign payload_size_o  = out_res.payload_size;

  a_rec_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_end_i |=> rec_valid)
    else $error("frame end did not produce a header record");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> ((q_count != 2'd2) || pop))
    else $error("result queue overflow");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

// ===== tb/mesh_frame_header_parser_tb.sv =====
// Self-checking testbench for mesh_frame_header_parser.
// Drives frames byte by byte and checks every header result against a predictor or a directed table entry.
// Depends on mfhp_pkg and the mesh_frame_header_parser RTL.
module mesh_frame_header_parser_tb import mfhp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxLen        = MaxFrameLenDefault;
  localparam int HoldOffCycles = 200;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 6;
  localparam int PhaseBytes    = 210;
  localparam int NumDirRows    = 21;

  typedef struct packed {
    logic [7:0]  m0;
    logic [7:0]  m1;
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [7:0]  src;
    logic [7:0]  b5;
    logic [15:0] seq;
    logic [7:0]  pl;
    logic [7:0]  hop;
    logic [10:0] len;
    logic        has_want;
    res_t        want;
  } frame_row_t;

  localparam frame_row_t DirRows [NumDirRows] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 11'd6, 1'b1,
      '{1'b1, KIND_REPORT, 8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 8'hFF, 4'd0, 9'd6, 10'd0}},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 16'h0000, 8'h00, 8'h00, 11'd5, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h12, 8'h34, 16'h0000, 8'h00, 8'h00, 11'd4, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 11'd8, 1'b1,
      '{1'b1, KIND_PATH_REQ, 8'h00, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 4'd0, 9'd0, 10'd0}},
    '{8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h80, 16'h0001, 8'h00, 8'h00, 11'd8, 1'b1,
      '{1'b1, KIND_ACK, 8'h01, 8'h80, 16'h0001, 8'h00, 8'h00, 8'h00, 4'd0, 9'd0, 10'd0}},
    '{8'h00, 8'h00, 8'h00, 8'h02, 8'h5A, 8'hA5, 16'h1234, 8'h03, 8'h00, 11'd12, 1'b0, '0},
    '{8'h00, 8'h00, 8'h00, 8'h02, 8'h5A, 8'hA5, 16'h1234, 8'h03, 8'h00, 11'd11, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h33, 8'h44, 16'h5566, 8'h02, 8'h07, 11'd12, 1'b1,
      '{1'b1, KIND_DATA, 8'h33, 8'h44, 16'h5566, 8'h02, 8'h07, 8'h00, 4'd10, 9'd0, 10'd0}},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h33, 8'h44, 16'h5566, 8'h02, 8'h07, 11'd15, 1'b0, '0},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h33, 8'h44, 16'h5566, 8'h00, 8'h07, 11'd9, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h05, 8'h21, 8'h43, 16'h8765, 8'h00, 8'h00, 11'd10, 1'b1, '0},
    '{8'h00, 8'h01, 8'h00, 8'h00, 8'h21, 8'h43, 16'h0000, 8'h00, 8'h00, 11'd6, 1'b1, '0},
    '{8'h00, 8'h00, 8'h80, 8'h00, 8'h21, 8'h43, 16'h0000, 8'h00, 8'h00, 11'd6, 1'b1, '0},
    '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h21, 8'h43, 16'h0000, 8'h00, 8'h00, 11'd6, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 11'd1, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'hC3, 8'h3C, 16'hA55A, 8'hFF, 8'hFF, 11'd300, 1'b0, '0},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'h88, 16'h0000, 8'h00, 8'h00, 11'd1023, 1'b1,
      '{1'b1, KIND_REPORT, 8'h77, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h88, 4'd0, 9'd6,
        10'd1017}},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'h88, 16'h0000, 8'h00, 8'h00, 11'd1026, 1'b1, '0},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h9A, 8'hBC, 16'hBEEF, 8'h00, 8'hFE, 11'd10, 1'b1,
      '{1'b1, KIND_DATA, 8'h9A, 8'hBC, 16'hBEEF, 8'h00, 8'hFE, 8'h00, 4'd10, 9'd0, 10'd0}},
    '{8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 16'h0304, 8'h00, 8'h00, 11'd9, 1'b0, '0},
    '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE1, 8'h1E, 16'h7F80, 8'h09, 8'h00, 11'd20, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall_o;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic        out_valid_o;
  logic        out_stall;
  logic        frame_ok_o;
  logic [2:0]  frame_kind_o;
  logic [7:0]  src_node_o;
  logic [7:0]  dst_node_o;
  logic [15:0] seq_num_o;
  logic [7:0]  path_size_o;
  logic [7:0]  hop_index_o;
  logic [7:0]  report_count_o;
  logic [3:0]  path_start_o;
  logic [8:0]  payload_start_o;
  logic [9:0]  payload_size_o;

  cfg_t       cfg_model;
  int         pos_q;
  logic       hdr_bad_q;
  logic [7:0] type_q;
  logic [7:0] src_q;
  logic [7:0] b5_q;
  logic [15:0] seq_q;
  logic [7:0] plen_q;
  logic [7:0] hop_q;

  res_t       expected_headers[$];
  res_t       checked_header;
  logic       typed_valid;
  res_t       typed_header;
  logic [7:0] frame_bytes[$];
  int         burst_left;
  int         hold_requests;
  int         holds_done;
  int         rx_tick;
  int         idle_cycles;
  int         fail_count;

  mesh_frame_header_parser #(
    .MAX_FRAME_LEN(MaxLen)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .frame_end_i    (frame_end),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .frame_ok_o     (frame_ok_o),
    .frame_kind_o   (frame_kind_o),
    .src_node_o     (src_node_o),
    .dst_node_o     (dst_node_o),
    .seq_num_o      (seq_num_o),
    .path_size_o    (path_size_o),
    .hop_index_o    (hop_index_o),
    .report_count_o (report_count_o),
    .path_start_o   (path_start_o),
    .payload_start_o(payload_start_o),
    .payload_size_o (payload_size_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_frame_state();
    pos_q     = 0;
    hdr_bad_q = 1'b0;
    type_q    = '0;
    src_q     = '0;
    b5_q      = '0;
    seq_q     = '0;
    plen_q    = '0;
    hop_q     = '0;
  endfunction

  function automatic logic [9:0] clip_payload(input int n);
    return (n > PayloadMax) ? 10'(PayloadMax) : 10'(n);
  endfunction

  function automatic void parse_header_byte(input logic [7:0] b, input logic last,
                                            output logic has_res, output res_t res);
    int   len;
    int   pl;
    logic ok;
    has_res = 1'b0;
    res     = '0;
    case (pos_q)
      BytePosMagic0:  if (b != cfg_model.magic_first) hdr_bad_q = 1'b1;
      BytePosMagic1:  if (b != cfg_model.magic_second) hdr_bad_q = 1'b1;
      BytePosVersion: if (b != cfg_model.proto_version) hdr_bad_q = 1'b1;
      BytePosType:    type_q = b;
      BytePosSource:  src_q = b;
      BytePosByte5:   b5_q = b;
      BytePosSeqLow:  seq_q[7:0] = b;
      BytePosSeqHigh: seq_q[15:8] = b;
      BytePosPathLen: plen_q = b;
      BytePosHop:     hop_q = b;
      default: ;
    endcase
    if (pos_q <= MaxLen) pos_q++;
    if (!last) return;

    has_res = 1'b1;
    len     = pos_q;
    pl      = plen_q;
    ok      = 1'b0;
    if (len >= MinLenAny && len <= MaxLen && !hdr_bad_q) begin
      if (type_q == cfg_model.code_report) begin
        if (len >= MinLenReport) begin
          ok                = 1'b1;
          res.kind          = KIND_REPORT;
          res.count         = b5_q;
          res.payload_start = 9'(MinLenReport);
          res.payload_size  = clip_payload(len - MinLenReport);
        end
      end else if (type_q == cfg_model.code_path_req || type_q == cfg_model.code_ack) begin
        if (len >= MinLenShort) begin
          ok       = 1'b1;
          res.kind = (type_q == cfg_model.code_path_req) ? KIND_PATH_REQ : KIND_ACK;
          res.dst  = b5_q;
          res.seq  = seq_q;
        end
      end else if (type_q == cfg_model.code_path_rsp) begin
        if (len >= PathStartRsp + pl) begin
          ok             = 1'b1;
          res.kind       = KIND_PATH_RSP;
          res.dst        = b5_q;
          res.seq        = seq_q;
          res.path_size  = plen_q;
          res.path_start = 4'(PathStartRsp);
        end
      end else if (type_q == cfg_model.code_data) begin
        if (len >= PathStartData + pl) begin
          ok             = 1'b1;
          res.kind       = KIND_DATA;
          res.dst        = b5_q;
          res.seq        = seq_q;
          res.path_size  = plen_q;
          res.hop        = hop_q;
          res.path_start = 4'(PathStartData);
          if (len > PathStartData + pl) begin
            res.payload_start = 9'(PathStartData + pl);
            res.payload_size  = clip_payload(len - PathStartData - pl);
          end
        end
      end
    end
    if (ok) begin
      res.ok  = 1'b1;
      res.src = src_q;
    end else begin
      res = '0;
    end
    clear_frame_state();
  endfunction

  function automatic cfg_t random_config(input logic distinct);
    cfg_t       c;
    logic [7:0] codes [5];
    logic       clash;
    c.magic_first   = 8'($urandom);
    c.magic_second  = 8'($urandom);
    c.proto_version = 8'($urandom);
    for (int i = 0; i < 5; i++) begin
      do begin
        codes[i] = distinct ? 8'($urandom) : 8'($urandom_range(0, 2));
        clash    = 1'b0;
        for (int j = 0; j < i; j++) if (distinct && codes[j] == codes[i]) clash = 1'b1;
      end while (clash);
    end
    c.code_report   = codes[0];
    c.code_path_req = codes[1];
    c.code_path_rsp = codes[2];
    c.code_ack      = codes[3];
    c.code_data     = codes[4];
    return c;
  endfunction

  // Mostly well-formed frames of the current configuration, some truncated or with
  // a broken magic or version byte, plus frames of random type and pure noise.
  function automatic void build_random_frame();
    int         r;
    int         k;
    int         pl;
    int         full;
    int         idx;
    logic [7:0] code_of [5];
    frame_bytes.delete();
    r = $urandom_range(0, 99);
    if (r >= 90) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      return;
    end
    code_of = '{cfg_model.code_report, cfg_model.code_path_req, cfg_model.code_path_rsp,
                cfg_model.code_ack, cfg_model.code_data};
    k  = $urandom_range(0, 4);
    pl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    frame_bytes.push_back(cfg_model.magic_first);
    frame_bytes.push_back(cfg_model.magic_second);
    frame_bytes.push_back(cfg_model.proto_version);
    frame_bytes.push_back((r >= 80) ? 8'($urandom) : code_of[k]);
    repeat (4) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'(pl));
    frame_bytes.push_back(8'($urandom));
    if (r >= 80) begin
      full = $urandom_range(5, 20);
    end else begin
      case (k)
        0:       full = MinLenReport + $urandom_range(0, 20);
        2:       full = PathStartRsp + pl + $urandom_range(0, 3);
        4:       full = PathStartData + pl +
                        (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        default: full = MinLenShort + $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 9) == 0) full = $urandom_range(1, full - 1);
    end
    while (frame_bytes.size() > full) void'(frame_bytes.pop_back());
    while (frame_bytes.size() < full) frame_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 19) == 0) begin
      idx = $urandom_range(0, 2);
      if (idx < frame_bytes.size())
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic has_res;
    res_t res;
    int   gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      gap        = $urandom_range(1, 5);
      @(negedge clk_i);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid  = 1'b1;
    rx_byte   = b;
    frame_end = last;
    do @(posedge clk_i); while (in_stall_o);
    parse_header_byte(b, last, has_res, res);
    if (has_res) expected_headers.push_back(typed_valid ? typed_header : res);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_headers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_MAGIC_FIRST:   cfg_model.magic_first   = val;
      REG_MAGIC_SECOND:  cfg_model.magic_second  = val;
      REG_PROTO_VERSION: cfg_model.proto_version = val;
      REG_CODE_REPORT:   cfg_model.code_report   = val;
      REG_CODE_PATH_REQ: cfg_model.code_path_req = val;
      REG_CODE_PATH_RSP: cfg_model.code_path_rsp = val;
      REG_CODE_ACK:      cfg_model.code_ack      = val;
      default:           cfg_model.code_data     = val;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    wait_idle();
    write_reg(REG_MAGIC_FIRST, c.magic_first);
    write_reg(REG_MAGIC_SECOND, c.magic_second);
    write_reg(REG_PROTO_VERSION, c.proto_version);
    write_reg(REG_CODE_REPORT, c.code_report);
    write_reg(REG_CODE_PATH_REQ, c.code_path_req);
    write_reg(REG_CODE_PATH_RSP, c.code_path_rsp);
    write_reg(REG_CODE_ACK, c.code_ack);
    write_reg(REG_CODE_DATA, c.code_data);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    out_stall  = 1'b0;
    holds_done = 0;
    rx_tick    = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall = 1'b1;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        rx_tick++;
        case (rx_tick[7:6])
          2'd0:    out_stall = 1'b0;
          2'd1:    out_stall = ($urandom_range(0, 1) == 0);
          2'd2:    out_stall = (rx_tick[2:0] < 3'd3);
          default: out_stall = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (expected_headers.size() == 0) begin
          $error("header result with no frame end waiting");
          fail_count++;
        end else begin
          checked_header = expected_headers.pop_front();
          check_field("frame_ok", checked_header.ok, frame_ok_o);
          check_field("frame_kind", checked_header.kind, frame_kind_o);
          check_field("src_node", checked_header.src, src_node_o);
          check_field("dst_node", checked_header.dst, dst_node_o);
          check_field("seq_num", checked_header.seq, seq_num_o);
          check_field("path_size", checked_header.path_size, path_size_o);
          check_field("hop_index", checked_header.hop, hop_index_o);
          check_field("report_count", checked_header.count, report_count_o);
          check_field("path_start", checked_header.path_start, path_start_o);
          check_field("payload_start", checked_header.payload_start, payload_start_o);
          check_field("payload_size", checked_header.payload_size, payload_size_o);
        end
      end
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    frame_row_t  row;
    cfg_t        c;
    logic [79:0] hdr;
    int          sent;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    frame_end     = 1'b0;
    typed_valid   = 1'b0;
    typed_header  = '0;
    burst_left    = 0;
    hold_requests = 0;
    idle_cycles   = 0;
    fail_count    = 0;
    cfg_model     = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04};
    clear_frame_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumDirRows; r++) begin
      row = DirRows[r];
      hdr = {row.m0, row.m1, row.ver, row.typ, row.src, row.b5,
             row.seq[7:0], row.seq[15:8], row.pl, row.hop};
      frame_bytes.delete();
      for (int i = 0; i < row.len; i++)
        frame_bytes.push_back((i < 10) ? hdr[79 - 8 * i -: 8] : 8'($urandom));
      typed_valid  = row.has_want;
      typed_header = row.want;
      send_frame();
    end
    typed_valid = 1'b0;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       c = random_config(1'b1);
        1:       c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01};
        2:       c = random_config(1'b0);
        default: c = random_config(1'b1);
      endcase
      apply_config(c);
      if (p == 1) begin
        // The receiver holds off while short frames keep coming, so the result
        // queue fills and the input backs up.
        @(posedge clk_i);
        hold_requests++;
        burst_left = 400;
        repeat (12) begin
          build_random_frame();
          send_frame();
        end
      end
      sent = 0;
      while (sent < PhaseBytes) begin
        build_random_frame();
        sent += frame_bytes.size();
        send_frame();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
